>>> hdl/bls_pkg.sv
// Shared types and constants for the Bresenham line stepper.
package bls_pkg;

   localparam int CoordBits = 16;
   localparam int ColorBits = 32;
   localparam int CfgBits = 15;
   localparam int DefQueueDepth = 4;

   localparam logic [CfgBits-1:0] SurfaceWidthReset = CfgBits'(1920);
   localparam logic [CfgBits-1:0] SurfaceHeightReset = CfgBits'(1080);

   typedef enum logic {
      OP_START = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic {
      CSR_SURFACE_WIDTH = 1'b0,
      CSR_SURFACE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic [CoordBits:0] abs_delta_type;
   typedef logic signed [CoordBits+1:0] neg_delta_type;
   typedef logic signed [CoordBits+2:0] error_type;
   typedef logic [ColorBits-1:0] color_type;
   typedef logic [CfgBits-1:0] extent_type;

   typedef struct packed {
      op_type operation;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      color_type line_color;
   } req_type;

   typedef struct packed {
      logic pixel_valid;
      coord_type pixel_x;
      coord_type pixel_y;
      logic inside_res;
      color_type pixel_color;
      logic last;
   } rsp_type;

   // Classified and pre-computed command between front and back.
   typedef struct packed {
      op_type operation;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      abs_delta_type abs_dx;
      neg_delta_type neg_dy;
      logic x_neg;
      logic y_neg;
      color_type color;
   } cmd_type;

   typedef struct packed {
      extent_type width;
      extent_type height;
   } surface_type;

endpackage

>>> hdl/bls_front.sv
// Front end: accepts items and computes line setup (deltas and step signs).
module bls_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  bls_pkg::req_type  req_payload,
   output logic              push_valid,
   input  logic              push_ready,
   output bls_pkg::cmd_type  push_cmd
);
   import bls_pkg::*;

   logic signed [CoordBits:0] diff_x;
   logic signed [CoordBits:0] diff_y;
   logic                      dx_neg;
   logic                      dy_neg;

   assign diff_x = {req_payload.end_x[CoordBits-1], req_payload.end_x}
                 - {req_payload.start_x[CoordBits-1], req_payload.start_x};
   assign diff_y = {req_payload.end_y[CoordBits-1], req_payload.end_y}
                 - {req_payload.start_y[CoordBits-1], req_payload.start_y};
   assign dx_neg = diff_x[CoordBits];
   assign dy_neg = diff_y[CoordBits];

   always_comb begin
      push_cmd.operation = req_payload.operation;
      push_cmd.start_x = req_payload.start_x;
      push_cmd.start_y = req_payload.start_y;
      push_cmd.end_x = req_payload.end_x;
      push_cmd.end_y = req_payload.end_y;
      push_cmd.color = req_payload.line_color;
      // step is negative unless start < end
      push_cmd.x_neg = dx_neg || (diff_x == '0);
      push_cmd.y_neg = dy_neg || (diff_y == '0);
      push_cmd.abs_dx = dx_neg ? abs_delta_type'(-diff_x) : abs_delta_type'(diff_x);
      push_cmd.neg_dy = dy_neg ? {diff_y[CoordBits], diff_y}
                               : -{diff_y[CoordBits], diff_y};
   end

   assign push_valid = req_valid;
   assign req_ready = push_ready;

endmodule

>>> hdl/bls_queue.sv
// Command queue between the front end and the stepping back end.
module bls_queue #(
   parameter int DEPTH = bls_pkg::DefQueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bls_pkg::cmd_type  push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output bls_pkg::cmd_type  pop_cmd
);
   import bls_pkg::*;

   localparam int PtrBits = $clog2(DEPTH);
   localparam int CntBits = $clog2(DEPTH + 1);

   cmd_type              mem_ff [DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 push_fire;
   logic                 pop_fire;

   assign push_ready = (count_ff != CntBits'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];
   assign push_fire = push_valid && push_ready;
   assign pop_fire = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(DEPTH))
      else $error("queue count over depth");
`endif

endmodule

>>> hdl/bls_back.sv
// Back end: Bresenham stepping state, inside test and result register.
module bls_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  bls_pkg::cmd_type      pop_cmd,
   input  bls_pkg::surface_type  surface,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bls_pkg::rsp_type      rsp_payload
);
   import bls_pkg::*;

   localparam int CmpW = ((CoordBits > CfgBits) ? CoordBits : CfgBits) + 1;

   coord_type      cur_x_ff, cur_x_in;
   coord_type      cur_y_ff, cur_y_in;
   coord_type      tgt_x_ff, tgt_x_in;
   coord_type      tgt_y_ff, tgt_y_in;
   logic           x_neg_ff, x_neg_in;
   logic           y_neg_ff, y_neg_in;
   abs_delta_type  adx_ff, adx_in;
   neg_delta_type  ndy_ff, ndy_in;
   error_type      err_ff, err_in;
   logic           active_ff, active_in;
   color_type      color_ff, color_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic                      fire;
   logic signed [CoordBits+3:0] e2;
   logic                      step_x;
   logic                      step_y;
   error_type                 err_step;
   logic                      at_end;
   logic                      in_surface;
   logic [CmpW-1:0]           x_ext, y_ext, w_ext, h_ext;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign fire = pop_valid && pop_ready;

   assign e2 = {err_ff, 1'b0};
   assign step_x = (e2 >= $signed({{2{ndy_ff[CoordBits+1]}}, ndy_ff}));
   assign step_y = (e2 <= $signed({3'b000, adx_ff}));
   assign err_step = err_ff
                   + (step_x ? {ndy_ff[CoordBits+1], ndy_ff} : error_type'(0))
                   + (step_y ? error_type'({2'b00, adx_ff}) : error_type'(0));

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      x_neg_in = x_neg_ff;
      y_neg_in = y_neg_ff;
      adx_in = adx_ff;
      ndy_in = ndy_ff;
      err_in = err_ff;
      color_in = color_ff;
      case (pop_cmd.operation)
         OP_START: begin
            cur_x_in = pop_cmd.start_x;
            cur_y_in = pop_cmd.start_y;
            tgt_x_in = pop_cmd.end_x;
            tgt_y_in = pop_cmd.end_y;
            x_neg_in = pop_cmd.x_neg;
            y_neg_in = pop_cmd.y_neg;
            adx_in = pop_cmd.abs_dx;
            ndy_in = pop_cmd.neg_dy;
            err_in = {pop_cmd.neg_dy[CoordBits+1], pop_cmd.neg_dy}
                   + error_type'({2'b00, pop_cmd.abs_dx});
            color_in = pop_cmd.color;
         end
         OP_ADVANCE: begin
            if (active_ff) begin
               err_in = err_step;
               if (step_x) begin
                  cur_x_in = cur_x_ff + (x_neg_ff ? '1 : CoordBits'(1));
               end
               if (step_y) begin
                  cur_y_in = cur_y_ff + (y_neg_ff ? '1 : CoordBits'(1));
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign x_ext = {{(CmpW - CoordBits){cur_x_in[CoordBits-1]}}, cur_x_in};
   assign y_ext = {{(CmpW - CoordBits){cur_y_in[CoordBits-1]}}, cur_y_in};
   assign w_ext = {{(CmpW - CfgBits){1'b0}}, surface.width};
   assign h_ext = {{(CmpW - CfgBits){1'b0}}, surface.height};
   assign in_surface = !cur_x_in[CoordBits-1] && !cur_y_in[CoordBits-1]
                    && (x_ext < w_ext) && (y_ext < h_ext);
   assign at_end = (cur_x_in == tgt_x_in) && (cur_y_in == tgt_y_in);

   always_comb begin
      active_in = active_ff;
      rsp_in = '0;
      if ((pop_cmd.operation == OP_START) || active_ff) begin
         rsp_in.pixel_valid = 1'b1;
         rsp_in.pixel_x = cur_x_in;
         rsp_in.pixel_y = cur_y_in;
         rsp_in.inside_res = in_surface;
         rsp_in.pixel_color = color_in;
         rsp_in.last = at_end;
         active_in = !at_end;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            active_ff <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         tgt_x_ff <= tgt_x_in;
         tgt_y_ff <= tgt_y_in;
         x_neg_ff <= x_neg_in;
         y_neg_ff <= y_neg_in;
         adx_ff <= adx_in;
         ndy_ff <= ndy_in;
         err_ff <= err_in;
         color_ff <= color_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.pixel_valid |->
         rsp_ff.pixel_x == '0 && rsp_ff.pixel_y == '0 && !rsp_ff.inside_res
         && rsp_ff.pixel_color == '0 && !rsp_ff.last)
      else $error("advance without line gave nonzero fields");
`endif

`ifndef SYNTHESIS
   a_active_off_end: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !(cur_x_ff == tgt_x_ff && cur_y_ff == tgt_y_ff))
      else $error("line active at its end point");
`endif

`ifndef SYNTHESIS
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_in.last |=> !active_ff)
      else $error("line still active after last pixel");
`endif

endmodule

>>> hdl/bresenham_line_stepper.sv
// Top level of the Bresenham line stepper: surface registers, front, queue and back.
//
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_ready  | operation, endpoints, line_color
//  rsp_     | out       | rsp_valid/rsp_ready  | pixel, inside flag, color, last
//  csr_     | in        | csr_we               | csr_index, csr_wdata (15 bits)
//
// One item per clock sustained while rsp_ready is high; each item yields exactly one result item.
// The combinational error step in the back end, registered with each result,
// sets the rate.
// Reset clears the queue and the active line and loads width 1920, height 1080.
// The QUEUE_DEPTH-entry queue lets the input side keep accepting while a
// result waits on rsp_ready.
module bresenham_line_stepper #(
   parameter int QUEUE_DEPTH = bls_pkg::DefQueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bls_pkg::req_type        req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bls_pkg::rsp_type        rsp_payload,
   input  logic                    csr_we,
   input  bls_pkg::csr_index_type  csr_index,
   input  logic [bls_pkg::CfgBits-1:0] csr_wdata
);
   import bls_pkg::*;

   surface_type surface_ff;
   logic        push_valid;
   logic        push_ready;
   cmd_type     push_cmd;
   logic        pop_valid;
   logic        pop_ready;
   cmd_type     pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         surface_ff.width <= SurfaceWidthReset;
         surface_ff.height <= SurfaceHeightReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SURFACE_WIDTH: surface_ff.width <= csr_wdata;
            CSR_SURFACE_HEIGHT: surface_ff.height <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bls_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   bls_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   bls_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_cmd     (pop_cmd),
      .surface     (surface_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> tb/sv/testbench.sv
// Testbench for bresenham_line_stepper: directed rows, then random lines checked by a predictor.
`timescale 1ns / 100ps

module testbench;
   import bls_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int NumProbes = 23;
   localparam int ItemsPerPhase = 250;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } probe_row;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_SURFACE_WIDTH;
   extent_type    csr_wdata = '0;

   bresenham_line_stepper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // line tracer state
   coord_type                    pos_x = '0, pos_y = '0, goal_x = '0, goal_y = '0;
   logic                         step_left = 1'b0, step_down = 1'b0;
   logic signed [CoordBits+1:0]  span_x = '0, span_y_neg = '0;
   logic signed [CoordBits+2:0]  bres_err = '0;
   logic                         tracing = 1'b0;
   color_type                    ink = '0;
   extent_type                   surf_w = SurfaceWidthReset, surf_h = SurfaceHeightReset;

   rsp_type pixels_due[$];
   int      bad_pixels = 0;
   int      sent_items = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic trace_pixel(input req_type item, output rsp_type pix);
      logic signed [CoordBits+3:0] twice_err;
      int dx, dy;
      pix = '0;
      if (item.operation == OP_START) begin
         pos_x = item.start_x;
         pos_y = item.start_y;
         goal_x = item.end_x;
         goal_y = item.end_y;
         step_left = !(item.start_x < item.end_x);
         step_down = !(item.start_y < item.end_y);
         dx = int'(item.end_x) - int'(item.start_x);
         dy = int'(item.end_y) - int'(item.start_y);
         span_x = (dx > 0) ? (CoordBits+2)'(dx) : (CoordBits+2)'(-dx);
         span_y_neg = (dy > 0) ? (CoordBits+2)'(-dy) : (CoordBits+2)'(dy);
         bres_err = span_x + span_y_neg;
         ink = item.line_color;
      end else if (!tracing) begin
         return;
      end else begin
         twice_err = {bres_err, 1'b0};
         if (twice_err >= span_y_neg) begin
            bres_err = bres_err + span_y_neg;
            pos_x = coord_type'(int'(pos_x) + (step_left ? -1 : 1));
         end
         if (twice_err <= span_x) begin
            bres_err = bres_err + span_x;
            pos_y = coord_type'(int'(pos_y) + (step_down ? -1 : 1));
         end
      end
      pix.pixel_valid = 1'b1;
      pix.pixel_x = pos_x;
      pix.pixel_y = pos_y;
      pix.inside_res = (pos_x >= 0) && (pos_y >= 0) &&
                       (int'(pos_x) < int'(surf_w)) && (int'(pos_y) < int'(surf_h));
      pix.pixel_color = ink;
      pix.last = (pos_x == goal_x) && (pos_y == goal_y);
      tracing = !pix.last;
   endtask

   task automatic push_req(input req_type item, input bit typed, input rsp_type want);
      rsp_type pix;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      trace_pixel(item, pix);
      pixels_due.push_back(typed ? want : pix);
      sent_items++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_surface(input extent_type w, input extent_type h);
      csr_we <= 1'b1;
      csr_index <= CSR_SURFACE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_SURFACE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      surf_w = w;
      surf_h = h;
   endtask

   function automatic req_type mk_start(int x0, int y0, int x1, int y1, color_type c);
      req_type r;
      r.operation = OP_START;
      r.start_x = coord_type'(x0);
      r.start_y = coord_type'(y0);
      r.end_x = coord_type'(x1);
      r.end_y = coord_type'(y1);
      r.line_color = c;
      return r;
   endfunction

   // advance items carry junk in the unused fields
   function automatic req_type mk_step();
      req_type r;
      r.operation = OP_ADVANCE;
      r.start_x = coord_type'($urandom);
      r.start_y = coord_type'($urandom);
      r.end_x = coord_type'($urandom);
      r.end_y = coord_type'($urandom);
      r.line_color = $urandom;
      return r;
   endfunction

   function automatic rsp_type mk_pix(int x, int y, bit in_flag, color_type c, bit fin);
      rsp_type p;
      p.pixel_valid = 1'b1;
      p.pixel_x = coord_type'(x);
      p.pixel_y = coord_type'(y);
      p.inside_res = in_flag;
      p.pixel_color = c;
      p.last = fin;
      return p;
   endfunction

   function automatic coord_type pick_coord(int extent);
      int v;
      if ($urandom_range(1) == 1) v = int'($urandom_range(65535)) - 32768;
      else v = int'($urandom_range(extent + 32)) - 16;
      if (v > 32767) v = 32767;
      return coord_type'(v);
   endfunction

   function automatic coord_type near_coord(coord_type base, int reach);
      int v;
      v = int'(base) + int'($urandom_range(2 * reach)) - reach;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return coord_type'(v);
   endfunction

   // mostly whole lines traced to their end point, some abandoned or far-flung
   task automatic run_lines(input int goal);
      req_type r;
      int kind, reach, budget, n;
      while (sent_items < goal) begin
         kind = $urandom_range(99);
         if (kind < 6) begin
            push_req(mk_step(), 1'b0, '0);
            continue;
         end
         r.operation = OP_START;
         r.line_color = $urandom;
         r.start_x = pick_coord(int'(surf_w));
         r.start_y = pick_coord(int'(surf_h));
         reach = (kind < 85) ? 12 : 300;
         r.end_x = near_coord(r.start_x, reach);
         r.end_y = near_coord(r.start_y, reach);
         budget = 100000;
         if (kind >= 94) begin
            r.end_x = coord_type'($urandom);
            r.end_y = coord_type'($urandom);
            budget = $urandom_range(20);
         end else if (kind >= 88) begin
            budget = $urandom_range(8);
         end
         push_req(r, 1'b0, '0);
         n = 0;
         while (tracing && n < budget) begin
            push_req(mk_step(), 1'b0, '0);
            n++;
         end
         if (!tracing && $urandom_range(9) == 0) push_req(mk_step(), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixels_due.size() == 0) begin
            bad_pixels++;
            if (bad_pixels <= 10)
               $display("unexpected pixel item: x=%0d y=%0d", rsp_payload.pixel_x,
                        rsp_payload.pixel_y);
         end else begin
            want = pixels_due.pop_front();
            if (rsp_payload.pixel_valid !== want.pixel_valid ||
                rsp_payload.pixel_x !== want.pixel_x ||
                rsp_payload.pixel_y !== want.pixel_y ||
                rsp_payload.inside_res !== want.inside_res ||
                rsp_payload.pixel_color !== want.pixel_color ||
                rsp_payload.last !== want.last) begin
               bad_pixels++;
               if (bad_pixels <= 10) begin
                  $display("pixel mismatch: expected v=%0b x=%0d y=%0d in=%0b c=%08h last=%0b",
                           want.pixel_valid, want.pixel_x, want.pixel_y, want.inside_res,
                           want.pixel_color, want.last);
                  $display("                got      v=%0b x=%0d y=%0d in=%0b c=%08h last=%0b",
                           rsp_payload.pixel_valid, rsp_payload.pixel_x, rsp_payload.pixel_y,
                           rsp_payload.inside_res, rsp_payload.pixel_color, rsp_payload.last);
               end
            end
         end
      end
   end

   initial begin
      probe_row   probes [NumProbes];
      extent_type w, h;
      probes = '{
         '{mk_step(), 1'b1, '0},
         '{mk_start(5, 5, 5, 5, 32'hDEADBEEF), 1'b1, mk_pix(5, 5, 1, 32'hDEADBEEF, 1)},
         '{mk_step(), 1'b1, '0},
         '{mk_start(-32768, -32768, -32768, -32768, 32'hFFFFFFFF), 1'b1,
           mk_pix(-32768, -32768, 0, 32'hFFFFFFFF, 1)},
         '{mk_start(32767, 32767, 32767, 32767, 32'h0), 1'b1,
           mk_pix(32767, 32767, 0, 32'h0, 1)},
         '{mk_start(0, 0, 3, 1, 32'h11223344), 1'b1, mk_pix(0, 0, 1, 32'h11223344, 0)},
         '{mk_step(), 1'b0, '0},
         '{mk_step(), 1'b0, '0},
         '{mk_step(), 1'b0, '0},
         '{mk_start(0, 0, -1, -3, 32'h55AA55AA), 1'b1, mk_pix(0, 0, 1, 32'h55AA55AA, 0)},
         '{mk_step(), 1'b0, '0},
         '{mk_step(), 1'b0, '0},
         '{mk_step(), 1'b0, '0},
         '{mk_start(10, 0, 7, 2, 32'h0F0F0F0F), 1'b0, '0},
         '{mk_step(), 1'b0, '0},
         '{mk_start(1919, 1079, 1920, 1080, 32'hA5A5A5A5), 1'b1,
           mk_pix(1919, 1079, 1, 32'hA5A5A5A5, 0)},
         '{mk_step(), 1'b0, '0},
         '{mk_step(), 1'b1, '0},
         '{mk_start(32767, -32768, -32768, 32767, 32'h80000001), 1'b1,
           mk_pix(32767, -32768, 0, 32'h80000001, 0)},
         '{mk_step(), 1'b0, '0},
         '{mk_step(), 1'b0, '0},
         '{mk_start(-1, 0, 0, -1, 32'h7FFFFFFE), 1'b1, mk_pix(-1, 0, 0, 32'h7FFFFFFE, 0)},
         '{mk_step(), 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 28;
      recv_idle_pct = 86;
      for (int i = 0; i < NumProbes; i++) push_req(probes[i].item, probes[i].typed, probes[i].want);
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct = (phase < 2) ? 28 : (phase < 4) ? 86 : 0;
         recv_idle_pct = (phase < 2) ? 86 : (phase < 4) ? 28 : 0;
         case (phase)
            0: begin w = extent_type'(640); h = extent_type'(480); end
            1: begin w = extent_type'(0); h = extent_type'(32767); end
            2: begin w = extent_type'(32767); h = extent_type'(0); end
            3: begin w = extent_type'(32767); h = extent_type'(32767); end
            4: begin w = extent_type'(1); h = extent_type'(1); end
            default: begin
               w = extent_type'($urandom_range(32767));
               h = extent_type'($urandom_range(32767));
            end
         endcase
         set_surface(w, h);
         run_lines(sent_items + ItemsPerPhase);
         settle();
      end

      repeat (10) @(posedge clock);
      if (bad_pixels == 0 && pixels_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
